[hw/rtl/fmb_pkg.sv]
// shared types and constants of the framed message builder
package fmb_pkg;

  typedef enum logic {
    KIND_START   = 1'b0,
    KIND_PAYLOAD = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  msg_id;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } out_item_t;

  // command handed from the front to the back
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  msg_id;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last;
  } cmd_t;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCw    = $clog2(FifoDepth + 1);

  localparam logic [7:0]  PipeByte   = 8'h03;
  localparam logic [7:0]  FillByte   = 8'h00;
  localparam logic [7:0]  EscByte    = 8'hFF;
  localparam logic [7:0]  SumInit    = 8'h01;
  localparam logic [15:0] LongLenMin = 16'd255;

endpackage

[hw/rtl/fmb_front.sv]
// front end: tracks the open frame, drops stray bytes, marks the last byte
module fmb_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fmb_pkg::in_item_t in_data_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output fmb_pkg::cmd_t    cmd_o
);

  logic        open_q, open_d;
  logic [15:0] left_q, left_d;
  logic        accept;
  logic        drop;

  assign in_ready_o = cmd_ready_i;
  assign accept     = in_valid_i && cmd_ready_i;

  always_comb begin
    open_d = open_q;
    left_d = left_q;
    drop   = 1'b0;
    cmd_o.kind           = in_data_i.kind;
    cmd_o.msg_id         = in_data_i.msg_id;
    cmd_o.payload_length = in_data_i.payload_length;
    cmd_o.payload_byte   = in_data_i.payload_byte;
    cmd_o.last           = (left_q == 16'd1);
    unique case (in_data_i.kind)
      fmb_pkg::KIND_START: begin
        open_d = (in_data_i.payload_length != 16'd0);
        left_d = in_data_i.payload_length;
      end
      fmb_pkg::KIND_PAYLOAD: begin
        if (!open_q || left_q == 16'd0) begin
          open_d = 1'b0;
          drop   = 1'b1;
        end else begin
          left_d = left_q - 16'd1;
          if (left_q == 16'd1) open_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign cmd_valid_o = in_valid_i && !drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      left_q <= '0;
    end else if (accept) begin
      open_q <= open_d;
      left_q <= left_d;
    end
  end

endmodule

[hw/rtl/fmb_cmd_fifo.sv]
// small command queue between front and back
module fmb_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  fmb_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output fmb_pkg::cmd_t pop_data_o
);

  fmb_pkg::cmd_t                    mem_q [fmb_pkg::FifoDepth];
  logic [fmb_pkg::FifoAw-1:0]       wr_ptr_q, rd_ptr_q;
  logic [fmb_pkg::FifoCw-1:0]       count_q;
  logic                             push, pop;

  assign push_ready_o = (count_q != fmb_pkg::FifoCw'(fmb_pkg::FifoDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_ready_i && pop_valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      unique case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/fmb_back.sv]
// back end: sequences frame bytes and the checksum into the output register
module fmb_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  fmb_pkg::cmd_t     cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fmb_pkg::out_item_t out_data_o
);

  typedef enum logic [11:0] {
    P_HEAD  = 12'b0000_0000_0001,
    P_PIPE  = 12'b0000_0000_0010,
    P_FILL0 = 12'b0000_0000_0100,
    P_FILL1 = 12'b0000_0000_1000,
    P_FILL2 = 12'b0000_0001_0000,
    P_ID    = 12'b0000_0010_0000,
    P_LEN   = 12'b0000_0100_0000,
    P_ESC   = 12'b0000_1000_0000,
    P_HI    = 12'b0001_0000_0000,
    P_LO    = 12'b0010_0000_0000,
    P_DATA  = 12'b0100_0000_0000,
    P_CHK   = 12'b1000_0000_0000
  } phase_e;

  phase_e             phase_q, phase_d, cur;
  logic [7:0]         sum_q, sum_d;
  logic               out_valid_q;
  fmb_pkg::out_item_t out_q, out_d;
  logic               emit, done;

  assign emit = cmd_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    if (phase_q == P_HEAD) begin
      cur = (cmd_i.kind == fmb_pkg::KIND_START) ? P_PIPE : P_DATA;
    end else begin
      cur = phase_q;
    end
  end

  always_comb begin
    phase_d = cur;
    sum_d   = sum_q;
    done    = 1'b0;
    out_d.out_byte  = fmb_pkg::FillByte;
    out_d.frame_end = 1'b0;
    unique case (cur)
      P_PIPE: begin
        out_d.out_byte = fmb_pkg::PipeByte;
        phase_d = P_FILL0;
      end
      P_FILL0: phase_d = P_FILL1;
      P_FILL1: phase_d = P_FILL2;
      P_FILL2: phase_d = P_ID;
      P_ID: begin
        out_d.out_byte = cmd_i.msg_id;
        sum_d   = fmb_pkg::SumInit - cmd_i.msg_id;
        phase_d = (cmd_i.payload_length < fmb_pkg::LongLenMin) ? P_LEN : P_ESC;
      end
      P_LEN: begin
        out_d.out_byte = cmd_i.payload_length[7:0];
        sum_d = sum_q - cmd_i.payload_length[7:0];
        if (cmd_i.payload_length == 16'd0) begin
          phase_d = P_CHK;
        end else begin
          done = 1'b1;
        end
      end
      P_ESC: begin
        out_d.out_byte = fmb_pkg::EscByte;
        sum_d   = sum_q - fmb_pkg::EscByte;
        phase_d = P_HI;
      end
      P_HI: begin
        out_d.out_byte = cmd_i.payload_length[15:8];
        sum_d   = sum_q - cmd_i.payload_length[15:8];
        phase_d = P_LO;
      end
      P_LO: begin
        out_d.out_byte = cmd_i.payload_length[7:0];
        sum_d = sum_q - cmd_i.payload_length[7:0];
        done  = 1'b1;
      end
      P_DATA: begin
        out_d.out_byte = cmd_i.payload_byte;
        sum_d = sum_q - cmd_i.payload_byte;
        if (cmd_i.last) begin
          phase_d = P_CHK;
        end else begin
          done = 1'b1;
        end
      end
      P_CHK: begin
        out_d.out_byte  = sum_q;
        out_d.frame_end = 1'b1;
        done = 1'b1;
      end
      default: done = 1'b1;
    endcase
    if (done) phase_d = P_HEAD;
  end

  assign cmd_ready_o = emit && done;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (emit) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= P_HEAD;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        phase_q <= phase_d;
        sum_q   <= sum_d;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/framed_message_builder.sv]
// top level of the framed message builder
// Takes start and payload items and sends the frame out one byte per transfer:
// pipe byte, three fill bytes, id, length field (one byte, or escape plus high
// and low bytes from 255 up), the payload bytes, then the checksum with
// frame_end set. The output moves one byte per cycle while out_ready_i is high,
// and that sets the rate: a payload item yields one byte (two for the last
// one, which carries the checksum), a start item six or eight bytes (seven
// for an empty frame). A four-entry command queue parts input from output,
// so items are taken one per cycle while it has room, also while a result
// waits to be taken. Stray payload bytes outside a frame are taken and dropped.
module framed_message_builder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fmb_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fmb_pkg::out_item_t out_data_o
);

  logic          push_valid, push_ready;
  fmb_pkg::cmd_t push_cmd;
  logic          pop_valid, pop_ready;
  fmb_pkg::cmd_t pop_cmd;

  fmb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (push_valid),
    .cmd_ready_i (push_ready),
    .cmd_o       (push_cmd)
  );

  fmb_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_cmd)
  );

  fmb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
